FILE: rtl/core/chm_pkg.sv
// Shared types, constants and functions of the Chaskey MAC engine.
// No dependencies; every other rtl/core file refers to it by scoped names.
`default_nettype none

package chm_pkg;

  localparam int unsigned BLK_W   = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned ROUNDS  = 8;
  localparam int unsigned RND_W   = $clog2(ROUNDS);
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_TAG_BITS = 2'd2;

  localparam logic [7:0]       TAG_BITS_RST = 8'd64;
  localparam logic [BLK_W-1:0] DBL_POLY     = 128'h87;

  // one classified block on its way to the permutation
  typedef struct packed {
    logic [BLK_W-1:0] blk;   // block, masked when last and also padded when partial
    logic [BLK_W-1:0] sub;   // subkey for the output mask
    logic             last;
  } job_t;

  // multiply by x in GF(2^128)
  function automatic logic [BLK_W-1:0] chm_dbl(input logic [BLK_W-1:0] x);
    logic [BLK_W-1:0] r;
    r = {x[BLK_W-2:0], 1'b0};
    if (x[BLK_W-1]) begin
      r = r ^ DBL_POLY;
    end
    return r;
  endfunction

  // one ARX round; v0 is the most significant word
  function automatic logic [BLK_W-1:0] chm_round(input logic [BLK_W-1:0] s);
    logic [31:0] v0, v1, v2, v3;
    v0 = s[127:96];
    v1 = s[95:64];
    v2 = s[63:32];
    v3 = s[31:0];
    v0 = v0 + v1; v1 = {v1[26:0], v1[31:27]}; v1 = v1 ^ v0; v0 = {v0[15:0], v0[31:16]};
    v2 = v2 + v3; v3 = {v3[23:0], v3[31:24]}; v3 = v3 ^ v2;
    v0 = v0 + v3; v3 = {v3[18:0], v3[31:19]}; v3 = v3 ^ v0;
    v2 = v2 + v1; v1 = {v1[24:0], v1[31:25]}; v1 = v1 ^ v2; v2 = {v2[15:0], v2[31:16]};
    return {v0, v1, v2, v3};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/chm_front.sv
// Front end: pads and masks final blocks, picks the subkey, queues jobs.
// Depends on chm_pkg.
`default_nettype none

module chm_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [chm_pkg::BLK_W-1:0]  key_i,
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [63:0]                block_high_i,
  input  wire logic [63:0]                block_low_i,
  input  wire logic                       is_last_i,
  input  wire logic [7:0]                 valid_bits_i,
  output logic                            job_valid_o,
  output chm_pkg::job_t                   job_o,
  input  wire logic                       job_pop_i
);

  logic [chm_pkg::BLK_W-1:0] msg, keep, one_bit, padded, k1, k2, sub;
  logic                      full_blk;
  chm_pkg::job_t             job_in;

  chm_pkg::job_t               mem_q [chm_pkg::Q_DEPTH];
  logic [chm_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [chm_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic                        wr_en;

  always_comb begin
    msg      = {block_high_i, block_low_i};
    full_blk = valid_bits_i[7];
    keep     = ~({chm_pkg::BLK_W{1'b1}} >> valid_bits_i);
    one_bit  = {1'b1, {(chm_pkg::BLK_W-1){1'b0}}} >> valid_bits_i;
    padded   = (msg & keep) | one_bit;
    k1       = chm_pkg::chm_dbl(key_i);
    k2       = chm_pkg::chm_dbl(k1);
    sub      = full_blk ? k1 : k2;
    job_in.last = is_last_i;
    job_in.sub  = sub;
    if (is_last_i) begin
      job_in.blk = (full_blk ? msg : padded) ^ sub;
    end else begin
      job_in.blk = msg;
    end
  end

  assign full_o      = (cnt_q == chm_pkg::Q_CNT_W'(chm_pkg::Q_DEPTH));
  assign wr_en       = push_i && !full_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !job_pop_i) begin
      cnt_d = cnt_q + chm_pkg::Q_CNT_W'(1);
    end else if (!wr_en && job_pop_i) begin
      cnt_d = cnt_q - chm_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + chm_pkg::Q_PTR_W'(1);
      end
      if (job_pop_i) begin
        rd_ptr_q <= rd_ptr_q + chm_pkg::Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chm_back.sv
// Back end: iterates the ARX round over a job, keeps the chain between blocks,
// applies the output mask on final blocks. Depends on chm_pkg.
`default_nettype none

module chm_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [chm_pkg::BLK_W-1:0]  key_i,
  input  wire logic                       job_valid_i,
  input  wire chm_pkg::job_t              job_i,
  output logic                            job_pop_o,
  input  wire logic                       res_full_i,
  output logic                            res_push_o,
  output logic [chm_pkg::BLK_W-1:0]       res_o
);

  logic                      busy_q, last_q, in_msg_q;
  logic [chm_pkg::RND_W-1:0] cnt_q;
  logic [chm_pkg::BLK_W-1:0] v_q, sub_q;   // v_q doubles as the chain between blocks
  logic [chm_pkg::BLK_W-1:0] rnd_out, start;
  logic                      finish, stall;

  assign rnd_out    = chm_pkg::chm_round(v_q);
  assign finish     = busy_q && (cnt_q == chm_pkg::RND_W'(chm_pkg::ROUNDS - 1));
  assign stall      = finish && last_q && res_full_i;
  assign job_pop_o  = job_valid_i && !busy_q;
  assign res_push_o = finish && last_q && !res_full_i;
  assign res_o      = rnd_out ^ sub_q;
  assign start      = (in_msg_q ? v_q : key_i) ^ job_i.blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      last_q   <= 1'b0;
      in_msg_q <= 1'b0;
      cnt_q    <= '0;
    end else if (job_pop_o) begin
      busy_q <= 1'b1;
      last_q <= job_i.last;
      cnt_q  <= chm_pkg::RND_W'(1);
    end else if (finish) begin
      if (!stall) begin
        busy_q   <= 1'b0;
        in_msg_q <= !last_q;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + chm_pkg::RND_W'(1);
    end
  end

  // first round is taken in the load cycle
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      v_q   <= chm_pkg::chm_round(start);
      sub_q <= job_i.sub;
    end else if (busy_q && !stall) begin
      v_q <= rnd_out;
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> !busy_q)
    else $error("job taken while a block is in flight");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> busy_q && $stable(v_q) && $stable(cnt_q))
    else $error("state moved while the result queue was full");

  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !finish) |=> busy_q && (cnt_q == $past(cnt_q) + chm_pkg::RND_W'(1)))
    else $error("round counter skipped");

  a_push_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> !busy_q && !in_msg_q)
    else $error("message state not cleared after a tag");

endmodule

`default_nettype wire

FILE: rtl/core/chm_tagout.sv
// Result queue: holds masked final states and right-aligns the tag on the way out.
// Depends on chm_pkg.
`default_nettype none

module chm_tagout (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [7:0]                 tag_bits_i,
  input  wire logic                       res_push_i,
  input  wire logic [chm_pkg::BLK_W-1:0]  res_i,
  output logic                            res_full_o,
  output logic                            empty_o,
  input  wire logic                       pop_i,
  output logic [63:0]                     tag_high_o,
  output logic [63:0]                     tag_low_o
);

  logic [chm_pkg::BLK_W-1:0]   mem_q [chm_pkg::Q_DEPTH];
  logic [chm_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [chm_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic                        rd_en;
  logic [7:0]                  t_sat, sh;
  logic [chm_pkg::BLK_W-1:0]   head, tag;

  assign res_full_o = (cnt_q == chm_pkg::Q_CNT_W'(chm_pkg::Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign rd_en      = pop_i && !empty_o;
  assign head       = mem_q[rd_ptr_q];

  // lengths above 128 clamp to a full-width tag
  always_comb begin
    t_sat = (tag_bits_i > 8'd128) ? 8'd128 : tag_bits_i;
    sh    = 8'd128 - t_sat;
    tag   = (t_sat == 8'd0) ? '0 : (head >> sh[6:0]);
  end

  assign tag_high_o = tag[127:64];
  assign tag_low_o  = tag[63:0];

  always_comb begin
    cnt_d = cnt_q;
    if (res_push_i && !rd_en) begin
      cnt_d = cnt_q + chm_pkg::Q_CNT_W'(1);
    end else if (!res_push_i && rd_en) begin
      cnt_d = cnt_q - chm_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (res_push_i) begin
        wr_ptr_q <= wr_ptr_q + chm_pkg::Q_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + chm_pkg::Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chaskey_mac_engine.sv
// Chaskey MAC engine top level: configuration registers, front end, round engine
// and tag queue. Depends on chm_pkg, chm_front, chm_back, chm_tagout.
//
// Usage:
//   Input channel: an item is one 128-bit message block with is_last and
//   valid_bits; it is taken on a clock edge with push high and full low.
//   Result channel: one tag per message, on the final block; the oldest tag
//   sits on tag_high_o/tag_low_o while empty is low and leaves on pop.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 key high,
//   1 key low, 2 tag length); write only while the engine is idle.
// Timing:
//   The round engine loads a block along with its first round, then does one
//   round per cycle unless the tag queue is full at a final block's last round.
//   It takes a new block only once it is through with the last, and a two-entry
//   job queue lets inputs arrive back to back until it fills. A final block's
//   tag is written into the tag queue as its last round completes.
// Reset: clears both queues, the engine and message state; key reads as zero,
//   tag length as 64. When pop stalls, two tags are held, then the engine
//   holds its final round, then the job queue fills and full rises.
`default_nettype none

module chaskey_mac_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  input  wire logic        is_last_i,
  input  wire logic [7:0]  valid_bits_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      tag_high_o,
  output logic [63:0]      tag_low_o
);

  logic [63:0]               key_high_q, key_low_q;
  logic [7:0]                tag_bits_q;
  logic [chm_pkg::BLK_W-1:0] key;
  logic                      job_valid, job_pop, res_full, res_push;
  chm_pkg::job_t             job;
  logic [chm_pkg::BLK_W-1:0] res;

  assign key = {key_high_q, key_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      tag_bits_q <= chm_pkg::TAG_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        chm_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        chm_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        chm_pkg::REG_TAG_BITS: tag_bits_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  chm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key),
    .push_i       (push),
    .full_o       (full),
    .block_high_i (block_high_i),
    .block_low_i  (block_low_i),
    .is_last_i    (is_last_i),
    .valid_bits_i (valid_bits_i),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_pop_i    (job_pop)
  );

  chm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  chm_tagout u_tagout (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_bits_i (tag_bits_q),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty_o    (empty),
    .pop_i      (pop),
    .tag_high_o (tag_high_o),
    .tag_low_o  (tag_low_o)
  );

endmodule

`default_nettype wire
